/* design/sst_pkg.sv */
// Package for the slot session table admission core.
// Opcodes, status and event codes, field widths. No dependencies.
package sst_pkg;
    localparam int MaxSlotsDef = 32;

    localparam logic [2:0] OP_ACT   = 3'd0;
    localparam logic [2:0] OP_DEACT = 3'd1;
    localparam logic [2:0] OP_REG   = 3'd2;
    localparam logic [2:0] OP_DISH  = 3'd3;
    localparam logic [2:0] OP_DISS  = 3'd4;
    localparam logic [2:0] OP_FRAME = 3'd5;
    localparam logic [2:0] OP_CMD   = 3'd6;
    localparam logic [2:0] OP_QUERY = 3'd7;

    localparam logic [3:0] ST_EVENT = 4'd0;
    localparam logic [3:0] ST_NOOP  = 4'd1;
    localparam logic [3:0] ST_CMDOK = 4'd2;
    localparam logic [3:0] ST_QUERY = 4'd3;
    localparam logic [3:0] ST_LIFE  = 4'd4;
    localparam logic [3:0] ST_NOSES = 4'd5;
    localparam logic [3:0] ST_BADPL = 4'd6;
    localparam logic [3:0] ST_ALRDY = 4'd7;
    localparam logic [3:0] ST_STGEN = 4'd8;
    localparam logic [3:0] ST_NCONN = 4'd9;
    localparam logic [3:0] ST_NOFRM = 4'd10;
    localparam logic [3:0] ST_STTCK = 4'd11;
    localparam logic [3:0] ST_DUPTK = 4'd12;
    localparam logic [3:0] ST_BADCM = 4'd13;

    localparam logic [2:0] EV_ON    = 3'd0;
    localparam logic [2:0] EV_OFF   = 3'd1;
    localparam logic [2:0] EV_CONN  = 3'd2;
    localparam logic [2:0] EV_DISC  = 3'd3;
    localparam logic [2:0] EV_FRAME = 3'd4;

    typedef logic [3:0]  t_status;
    typedef logic [31:0] t_gen;
    typedef logic [63:0] t_tick;
endpackage

/* design/slot_session_table_admission_core.sv */
// Slot session table with per-tick command admission, top level.
// Depends on sst_pkg; the generic registered-read RAM sst_ram follows the top level.
//
// One item at a time: an item is taken on start while busy is low, and its
// single result appears on o_valid for one cycle, registered at the end of the
// decide state that follows the read state. Slot reads and writes go through two
// registered slot tables (slot generation; connected bit and last tick). A plain
// item keeps busy high through its read state and its decide-and-write state, so
// a new item is not taken before the last one is decided. A successful activate
// or deactivate also sweeps the table, one slot per cycle, clearing connected
// bits and last ticks. After reset busy stays high while the tables are cleared.
// The result is not held: the receiver must take it in the strobe cycle.
module slot_session_table_admission_core #(
    parameter int MAX_SLOTS = sst_pkg::MaxSlotsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_opcode,
    input  logic [7:0]         i_slot_number,
    input  logic [7:0]         i_slot_limit,
    input  logic [31:0]        i_handle_generation,
    input  logic [63:0]        i_command_tick,
    input  logic               i_command_ok,
    output logic               o_valid,
    output logic [3:0]         o_status,
    output logic [2:0]         o_event_kind,
    output logic [31:0]        o_event_number,
    output logic [31:0]        o_session_generation,
    output logic [7:0]         o_player_slot,
    output logic [31:0]        o_player_generation,
    output logic [63:0]        o_tick_out,
    output logic               o_slot_connected
);
    import sst_pkg::*;

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [7:0] MaxS = 8'(MAX_SLOTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_RESET = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic        r_act, n_act, r_frm, n_frm;
    t_tick       r_tick, n_tick;
    logic [7:0]  r_lim, n_lim;
    t_gen        r_sgen, n_sgen, r_evc, n_evc;

    logic [2:0]  r_op;
    logic [7:0]  r_sn, r_sl;
    t_gen        r_hg;
    t_tick       r_tk;
    logic        r_ok;

    logic        r_ov;
    t_status     r_ost;
    logic [2:0]  r_okd;
    t_gen        r_oen, r_osg, r_opg;
    logic [7:0]  r_ops;
    t_tick       r_otk;
    logic        r_oc;

    // slot tables: generation, and {connected, last_tick}
    localparam int SW = 1 + 64;
    logic          we_g, we_s;
    logic [IW-1:0] wa, ra;
    t_gen          wd_g, rd_g;
    logic [SW-1:0] wd_s, rd_s;

    sst_ram #(.WIDTH(32), .DEPTH(MAX_SLOTS)) u_gen (
        .i_clk(i_clk), .i_we(we_g), .i_waddr(wa), .i_wdata(wd_g),
        .i_raddr(ra), .o_rdata(rd_g)
    );

    sst_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_sta (
        .i_clk(i_clk), .i_we(we_s), .i_waddr(wa), .i_wdata(wd_s),
        .i_raddr(ra), .o_rdata(rd_s)
    );

    logic  sok, conn;
    t_gen  sg;
    t_tick lt;
    logic [7:0] sidx;
    assign sok  = (r_sn >= 8'd1) && (r_sn <= r_lim) && (r_sn <= MaxS);
    assign sidx = r_sn - 8'd1;
    assign ra   = sidx[IW-1:0];
    assign conn = rd_s[SW-1];
    assign sg   = rd_g;
    assign lt   = rd_s[63:0];

    t_status st;
    logic    ev;
    logic [2:0] kd;
    logic [7:0] ps;
    t_gen    pg;
    t_tick   tko;
    logic    oc;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt;
        n_act = r_act; n_frm = r_frm; n_tick = r_tick; n_lim = r_lim;
        n_sgen = r_sgen; n_evc = r_evc;
        we_g = 1'b0; we_s = 1'b0; wa = sidx[IW-1:0]; wd_g = rd_g; wd_s = rd_s;
        st = ST_NOOP; ev = 1'b0; kd = EV_ON; ps = '0; pg = '0; tko = '0; oc = 1'b0;
        case (r_state)
            S_IDLE: if (start) n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_op)
                    OP_ACT: begin
                        if (r_act) st = ST_NOOP;
                        else if (r_sl < 8'd1 || r_sl > MaxS) st = ST_LIFE;
                        else if (r_sgen == '1 || r_evc == '1) st = ST_LIFE;
                        else begin
                            n_act = 1'b1; n_frm = 1'b0; n_tick = '0; n_lim = r_sl;
                            n_sgen = r_sgen + 32'd1; ev = 1'b1; kd = EV_ON;
                            n_state = S_SWEEP; n_cnt = '0;
                        end
                    end
                    OP_DEACT: begin
                        if (!r_act) st = ST_NOOP;
                        else if (r_evc == '1) st = ST_LIFE;
                        else begin
                            ev = 1'b1; kd = EV_OFF; tko = r_tick;
                            n_act = 1'b0; n_frm = 1'b0; n_tick = '0; n_lim = '0;
                            n_state = S_SWEEP; n_cnt = '0;
                        end
                    end
                    OP_QUERY: begin
                        st = ST_QUERY;
                        if (sok) begin
                            ps = r_sn;
                            if (conn) begin pg = sg; oc = 1'b1; end
                        end
                    end
                    OP_CMD: begin
                        tko = r_tk; st = ST_NOSES;
                        if (r_act) begin
                            if (r_hg == '0 || !sok) st = ST_BADPL;
                            else if (!conn) st = ST_NCONN;
                            else if (sg != r_hg) st = ST_STGEN;
                            else if (!r_frm) st = ST_NOFRM;
                            else if (r_tk < r_tick) st = ST_STTCK;
                            else if (r_tk > r_tick) st = ST_LIFE;
                            else if (lt == r_tk) st = ST_DUPTK;
                            else if (!r_ok) st = ST_BADCM;
                            else begin
                                st = ST_CMDOK; we_s = 1'b1; wd_s = {conn, r_tk};
                            end
                        end
                    end
                    default: begin
                        if (!r_act) st = ST_NOSES;
                        else if (r_op == OP_FRAME) begin
                            if (r_tick == '1 || r_evc == '1) st = ST_LIFE;
                            else begin
                                n_tick = r_tick + 64'd1; n_frm = 1'b1;
                                ev = 1'b1; kd = EV_FRAME;
                            end
                        end else if (r_op == OP_REG) begin
                            if (!sok) st = ST_BADPL;
                            else if (conn) st = ST_ALRDY;
                            else if (sg == '1 || r_evc == '1) st = ST_LIFE;
                            else begin
                                we_g = 1'b1; wd_g = sg + 32'd1;
                                we_s = 1'b1; wd_s = {1'b1, 64'd0};
                                ev = 1'b1; kd = EV_CONN; ps = r_sn; pg = sg + 32'd1;
                            end
                        end else begin
                            if (r_op == OP_DISH && (r_hg == '0 || !sok)) st = ST_BADPL;
                            else if (r_op == OP_DISS && !sok) st = ST_BADPL;
                            else if (r_op == OP_DISH && sg != r_hg) st = ST_STGEN;
                            else if (!conn) st = ST_NOOP;
                            else if (r_evc == '1) st = ST_LIFE;
                            else begin
                                we_s = 1'b1; wd_s = {1'b0, 64'd0};
                                ev = 1'b1; kd = EV_DISC; ps = r_sn; pg = sg;
                            end
                        end
                    end
                endcase
                if (ev) begin
                    st = ST_EVENT; n_evc = r_evc + 32'd1;
                    if (kd != EV_OFF) tko = n_tick;
                end
            end
            S_SWEEP, S_RESET: begin
                wa = r_cnt[IW-1:0];
                we_s = 1'b1; wd_s = '0;
                // only reset clears generations; sweep keeps them
                we_g = (r_state == S_RESET); wd_g = '0;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(MAX_SLOTS - 1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RESET; r_cnt <= '0;
            r_act <= 1'b0; r_frm <= 1'b0; r_tick <= '0; r_lim <= '0;
            r_sgen <= '0; r_evc <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt;
            r_act <= n_act; r_frm <= n_frm; r_tick <= n_tick; r_lim <= n_lim;
            r_sgen <= n_sgen; r_evc <= n_evc;
            r_ov <= (r_state == S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op <= i_opcode; r_sn <= i_slot_number; r_sl <= i_slot_limit;
            r_hg <= i_handle_generation; r_tk <= i_command_tick; r_ok <= i_command_ok;
        end
        if (r_state == S_EXEC) begin
            r_ost <= st; r_okd <= ev ? kd : EV_ON;
            r_oen <= ev ? n_evc : '0; r_osg <= ev ? n_sgen : '0;
            r_ops <= ps; r_opg <= pg; r_otk <= tko; r_oc <= oc;
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_event_kind = r_okd;
    assign o_event_number = r_oen;
    assign o_session_generation = r_osg;
    assign o_player_slot = r_ops;
    assign o_player_generation = r_opg;
    assign o_tick_out = r_otk;
    assign o_slot_connected = r_oc;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_valid) else $error("missing result");
    a_busy_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 busy) else $error("busy dropped");
    a_evc_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_evc != $past(r_evc)) |-> (r_evc == $past(r_evc) + 32'd1))
        else $error("event counter jump");
    a_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lim <= MaxS) else $error("slot limit out of range");
endmodule

// Generic single-port-write RAM with registered read, used for the slot tables.
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
